// ===== design/led_blink_rainbow_sequencer_macros.svh =====
// Assertion macros for the pixel effect sequencer.
// Included by files that carry concurrent assertions; needs no package.
`ifndef LED_BLINK_RAINBOW_SEQUENCER_MACROS_SVH
`define LED_BLINK_RAINBOW_SEQUENCER_MACROS_SVH
`ifndef ASSERT_OFF
`define LBRS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LBRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`define LBRS_ASSERT_LATER4(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##4 (cons)) \
		else $error(msg);
`else
`define LBRS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define LBRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define LBRS_ASSERT_LATER4(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/lbrs_pkg.sv =====
// Shared constants, codes and control types of the pixel effect sequencer.
// Used by the interfaces, the controller, the datapath and the top level.
package lbrs_pkg;
	localparam int FUNC_W     = 3;
	localparam int TIMES_W    = 10;
	localparam int CH_W       = 8;
	localparam int HUE_W      = 9;
	localparam int PH_W       = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ON      = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_OFF     = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_BLINK   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CONT    = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_RAINBOW = 3'd5;

	localparam logic [1:0] MODE_STOPPED    = 2'd0;
	localparam logic [1:0] MODE_COUNTED    = 2'd1;
	localparam logic [1:0] MODE_CONTINUOUS = 2'd2;
	localparam logic [1:0] MODE_RAINBOW    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATION  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_STEP    = 3'd5;

	localparam logic [16:0]      MAX_BLINKS     = 17'd1023;
	localparam logic [CH_W-1:0]  SAT_RESET      = 8'd255;
	localparam logic [CH_W-1:0]  VAL_RESET      = 8'd25;
	localparam logic [HUE_W-1:0] HUE_STEP_RESET = 9'd3;

	typedef struct packed {
		logic accept;
		logic load;
	} lbrs_cmd_t;

	typedef struct packed {
		logic rainbow_tick;
	} lbrs_status_t;
endpackage

// ===== design/lbrs_if.sv =====
// Request channels of the pixel effect sequencer: commands and pixel results.
// Depends on lbrs_pkg for the field widths.
interface lbrs_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [lbrs_pkg::FUNC_W-1:0]      func;
	logic [lbrs_pkg::TIMES_W-1:0]     blink_times;
	modport source (output valid, func, blink_times, input ready);
	modport sink (input valid, func, blink_times, output ready);
endinterface

interface lbrs_pix_if;
	logic                        valid;
	logic                        ready;
	logic                        pixel_written;
	logic [lbrs_pkg::CH_W-1:0]   red;
	logic [lbrs_pkg::CH_W-1:0]   green;
	logic [lbrs_pkg::CH_W-1:0]   blue;
	logic                        effect_running;
	modport source (output valid, pixel_written, red, green, blue, effect_running,
		input ready);
	modport sink (input valid, pixel_written, red, green, blue, effect_running,
		output ready);
endinterface

// ===== design/lbrs_ctrl.sv =====
// Controller of the pixel effect sequencer: request handshakes and step sequencing.
// Depends on lbrs_pkg for the command and status types.
module lbrs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  lbrs_pkg::lbrs_status_t sts,
	output lbrs_pkg::lbrs_cmd_t    ctl,
	output logic                   pix_valid,
	input  logic                   pix_ready
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CONV1 = 3'd1;
	localparam logic [2:0] ST_CONV2 = 3'd2;
	localparam logic [2:0] ST_CONV3 = 3'd3;
	localparam logic [2:0] ST_CONV4 = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       valid_q;

	assign cmd_ready  = (state_q == ST_IDLE);
	assign ctl.accept = cmd_ready && cmd_valid;
	assign ctl.load   = (state_q == ST_DONE) && (!valid_q || pix_ready);
	assign pix_valid  = valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ctl.accept) begin
					state_d = sts.rainbow_tick ? ST_CONV1 : ST_DONE;
				end
			end
			ST_CONV1: state_d = ST_CONV2;
			ST_CONV2: state_d = ST_CONV3;
			ST_CONV3: state_d = ST_CONV4;
			ST_CONV4: state_d = ST_DONE;
			ST_DONE: begin
				if (ctl.load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				valid_q <= 1'b1;
			end else if (pix_ready) begin
				valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== design/lbrs_datapath.sv =====
// Datapath of the pixel effect sequencer: registers, effect state, hue to RGB
// conversion steps and the result register. Depends on lbrs_pkg.
module lbrs_datapath #(
	parameter logic [16:0] MAX_BLINKS = lbrs_pkg::MAX_BLINKS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lbrs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lbrs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [lbrs_pkg::FUNC_W-1:0]        func,
	input  logic [lbrs_pkg::TIMES_W-1:0]       blink_times,
	input  lbrs_pkg::lbrs_cmd_t                ctl,
	output lbrs_pkg::lbrs_status_t             sts,
	output logic                               pixel_written,
	output logic [lbrs_pkg::CH_W-1:0]          red,
	output logic [lbrs_pkg::CH_W-1:0]          green,
	output logic [lbrs_pkg::CH_W-1:0]          blue,
	output logic                               effect_running
);
	localparam logic [13:0] SCALE   = 14'd15300;
	localparam logic [10:0] RECIP   = 11'd1096;
	localparam logic [9:0]  HUE_MOD = 10'd360;

	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = 17'(x) + 17'(x[15:8]) + 17'd1;
		return s[15:8];
	endfunction

	logic [7:0]  red_q, green_q, blue_q, sat_q, val_q;
	logic [8:0]  step_q;
	logic [1:0]  mode_q, mode_d;
	logic [10:0] rem_q, rem_d, rem_dec;
	logic        phase_q, phase_d;
	logic [8:0]  hue_q, hue_d, hue_next;
	logic [9:0]  hue_sum, hue_red1, hue_red2;
	logic [9:0]  times_c;
	logic        wr, show, rb;

	logic        res_wr_q, res_run_q, res_rb_q;
	logic [7:0]  res_r_q, res_g_q, res_b_q;
	logic [8:0]  hue_s0_q;

	logic [2:0]  sec_c;
	logic [8:0]  base_c;
	logic [5:0]  f_c, g_c;
	logic [2:0]  sec_s1, sec_s2, sec_s3, sec_s4;
	logic [13:0] sf_s1, sg_s1;
	logic [15:0] pv_s1;
	logic [21:0] yq_s2, yt_s2, yq_s3, yt_s3;
	logic [7:0]  p_s2, p_s3, p_s4;
	logic [32:0] mq_c, mt_c;
	logic [7:0]  qh_s3, th_s3, q_s4, t_s4;
	logic [21:0] remq_c, remt_c;
	logic [7:0]  cr_c, cg_c, cb_c;

	logic        pix_wr_q, pix_run_q;
	logic [7:0]  pix_r_q, pix_g_q, pix_b_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			sat_q   <= lbrs_pkg::SAT_RESET;
			val_q   <= lbrs_pkg::VAL_RESET;
			step_q  <= lbrs_pkg::HUE_STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lbrs_pkg::REG_COLOR_RED:   red_q   <= cfg_data[7:0];
				lbrs_pkg::REG_COLOR_GREEN: green_q <= cfg_data[7:0];
				lbrs_pkg::REG_COLOR_BLUE:  blue_q  <= cfg_data[7:0];
				lbrs_pkg::REG_SATURATION:  sat_q   <= cfg_data[7:0];
				lbrs_pkg::REG_VALUE:       val_q   <= cfg_data[7:0];
				lbrs_pkg::REG_HUE_STEP:    step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hue advance: the sum stays below three times the modulus.
	always_comb begin
		hue_sum  = 10'(hue_q) + 10'(step_q);
		hue_red1 = (hue_sum >= HUE_MOD) ? hue_sum - HUE_MOD : hue_sum;
		hue_red2 = (hue_red1 >= HUE_MOD) ? hue_red1 - HUE_MOD : hue_red1;
		hue_next = hue_red2[8:0];
	end

	assign times_c = ({7'd0, blink_times} > MAX_BLINKS) ?
		MAX_BLINKS[9:0] : blink_times;
	assign rem_dec = (rem_q != '0) ? rem_q - 11'd1 : '0;
	assign sts.rainbow_tick = (func == lbrs_pkg::FUNC_TICK) &&
		(mode_q == lbrs_pkg::MODE_RAINBOW);

	always_comb begin
		mode_d  = mode_q;
		rem_d   = rem_q;
		phase_d = phase_q;
		hue_d   = hue_q;
		wr      = 1'b0;
		show    = 1'b0;
		rb      = 1'b0;
		case (func)
			lbrs_pkg::FUNC_TICK: begin
				case (mode_q)
					lbrs_pkg::MODE_RAINBOW: begin
						rb    = 1'b1;
						wr    = 1'b1;
						hue_d = hue_next;
					end
					lbrs_pkg::MODE_CONTINUOUS: begin
						phase_d = ~phase_q;
						wr      = 1'b1;
						show    = ~phase_q;
					end
					lbrs_pkg::MODE_COUNTED: begin
						rem_d = rem_dec;
						wr    = 1'b1;
						show  = rem_dec[0];
						if (rem_dec == '0) begin
							mode_d = lbrs_pkg::MODE_STOPPED;
						end
					end
					default: ;
				endcase
			end
			lbrs_pkg::FUNC_ON: begin
				mode_d = lbrs_pkg::MODE_STOPPED;
				wr     = 1'b1;
				show   = 1'b1;
			end
			lbrs_pkg::FUNC_OFF: begin
				mode_d = lbrs_pkg::MODE_STOPPED;
				wr     = 1'b1;
			end
			lbrs_pkg::FUNC_BLINK: begin
				if (times_c == '0) begin
					mode_d = lbrs_pkg::MODE_STOPPED;
					rem_d  = '0;
					wr     = 1'b1;
				end else begin
					mode_d = lbrs_pkg::MODE_COUNTED;
					rem_d  = {times_c, 1'b0};
				end
			end
			lbrs_pkg::FUNC_CONT: begin
				mode_d  = lbrs_pkg::MODE_CONTINUOUS;
				phase_d = 1'b0;
			end
			lbrs_pkg::FUNC_RAINBOW: mode_d = lbrs_pkg::MODE_RAINBOW;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lbrs_pkg::MODE_STOPPED;
			rem_q   <= '0;
			phase_q <= 1'b0;
			hue_q   <= '0;
		end else if (ctl.accept) begin
			mode_q  <= mode_d;
			rem_q   <= rem_d;
			phase_q <= phase_d;
			hue_q   <= hue_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			res_wr_q  <= wr;
			res_rb_q  <= rb;
			res_run_q <= (mode_d != lbrs_pkg::MODE_STOPPED);
			res_r_q   <= (wr && show) ? red_q : '0;
			res_g_q   <= (wr && show) ? green_q : '0;
			res_b_q   <= (wr && show) ? blue_q : '0;
			hue_s0_q  <= hue_q;
		end
	end

	// Hue sector and offset within the sector.
	always_comb begin
		if (hue_s0_q >= 9'd300) begin
			sec_c  = 3'd5;
			base_c = 9'd300;
		end else if (hue_s0_q >= 9'd240) begin
			sec_c  = 3'd4;
			base_c = 9'd240;
		end else if (hue_s0_q >= 9'd180) begin
			sec_c  = 3'd3;
			base_c = 9'd180;
		end else if (hue_s0_q >= 9'd120) begin
			sec_c  = 3'd2;
			base_c = 9'd120;
		end else if (hue_s0_q >= 9'd60) begin
			sec_c  = 3'd1;
			base_c = 9'd60;
		end else begin
			sec_c  = 3'd0;
			base_c = 9'd0;
		end
		f_c = 6'(hue_s0_q - base_c);
		g_c = 6'd60 - f_c;
	end

	// Division by 15300 uses a truncated reciprocal that undershoots by at
	// most one, so a single remainder check corrects it.
	always_comb begin
		mq_c   = 33'(yq_s2) * 33'(RECIP);
		mt_c   = 33'(yt_s2) * 33'(RECIP);
		remq_c = yq_s3 - 22'(qh_s3) * 22'(SCALE);
		remt_c = yt_s3 - 22'(th_s3) * 22'(SCALE);
	end

	always_ff @(posedge clk) begin
		sec_s1 <= sec_c;
		sf_s1  <= 14'(sat_q) * 14'(f_c);
		sg_s1  <= 14'(sat_q) * 14'(g_c);
		pv_s1  <= 16'(val_q) * 16'(8'd255 - sat_q);

		sec_s2 <= sec_s1;
		yq_s2  <= 22'(val_q) * 22'(SCALE - sf_s1);
		yt_s2  <= 22'(val_q) * 22'(SCALE - sg_s1);
		p_s2   <= div255(pv_s1);

		sec_s3 <= sec_s2;
		yq_s3  <= yq_s2;
		yt_s3  <= yt_s2;
		p_s3   <= p_s2;
		qh_s3  <= mq_c[31:24];
		th_s3  <= mt_c[31:24];

		sec_s4 <= sec_s3;
		p_s4   <= p_s3;
		q_s4   <= qh_s3 + 8'(remq_c >= 22'(SCALE));
		t_s4   <= th_s3 + 8'(remt_c >= 22'(SCALE));
	end

	always_comb begin
		case (sec_s4)
			3'd0: begin cr_c = val_q; cg_c = t_s4;  cb_c = p_s4;  end
			3'd1: begin cr_c = q_s4;  cg_c = val_q; cb_c = p_s4;  end
			3'd2: begin cr_c = p_s4;  cg_c = val_q; cb_c = t_s4;  end
			3'd3: begin cr_c = p_s4;  cg_c = q_s4;  cb_c = val_q; end
			3'd4: begin cr_c = t_s4;  cg_c = p_s4;  cb_c = val_q; end
			default: begin cr_c = val_q; cg_c = p_s4; cb_c = q_s4; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pix_wr_q  <= res_wr_q;
			pix_run_q <= res_run_q;
			pix_r_q   <= res_rb_q ? cr_c : res_r_q;
			pix_g_q   <= res_rb_q ? cg_c : res_g_q;
			pix_b_q   <= res_rb_q ? cb_c : res_b_q;
		end
	end

	assign pixel_written  = pix_wr_q;
	assign effect_running = pix_run_q;
	assign red            = pix_r_q;
	assign green          = pix_g_q;
	assign blue           = pix_b_q;
endmodule

// ===== design/led_blink_rainbow_sequencer.sv =====
// Pixel effect sequencer: on, off, blink and rainbow effects for one RGB pixel.
// A command or a blink tick passes through the result register to the output
// register; a rainbow tick also passes through the four registered steps of
// the hue converter. One item is in work at a time; a finished result waits
// in the output register while the next item is accepted. Reset clears the
// effect state and loads the register defaults at once.
`include "led_blink_rainbow_sequencer_macros.svh"
module led_blink_rainbow_sequencer #(
	parameter logic [16:0] MAX_BLINKS = lbrs_pkg::MAX_BLINKS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lbrs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lbrs_pkg::CFG_DATA_W-1:0]    cfg_data,
	lbrs_cmd_if.sink                           cmd,
	lbrs_pix_if.source                         pix
);
	lbrs_pkg::lbrs_cmd_t    ctl;
	lbrs_pkg::lbrs_status_t sts;
	logic                   rb_start;
	logic                   conv_hold;

	lbrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.sts       (sts),
		.ctl       (ctl),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready)
	);

	lbrs_datapath #(
		.MAX_BLINKS (MAX_BLINKS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.func           (cmd.func),
		.blink_times    (cmd.blink_times),
		.ctl            (ctl),
		.sts            (sts),
		.pixel_written  (pix.pixel_written),
		.red            (pix.red),
		.green          (pix.green),
		.blue           (pix.blue),
		.effect_running (pix.effect_running)
	);

	assign rb_start  = ctl.accept && sts.rainbow_tick;
	assign conv_hold = !cmd.ready && !ctl.load;

	`LBRS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, ctl.accept, !cmd.ready, "not busy")
	`LBRS_ASSERT_SAME(a_no_overwrite, clk, arst_n, ctl.load, !pix.valid || pix.ready, "overwrite")
	`LBRS_ASSERT_LATER4(a_rainbow_busy, clk, arst_n, rb_start, conv_hold, "conversion cut short")
endmodule

// ===== tb/led_blink_rainbow_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the pixel effect sequencer: commands and ticks go in
// over the command channel and every pixel result is checked against a predictor.
// Depends on lbrs_pkg, the lbrs_cmd_if and lbrs_pix_if interfaces and the top level.
module led_blink_rainbow_sequencer_tb;
	import lbrs_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [TIMES_W-1:0] blink_times;
	} cmd_item_t;

	typedef struct packed {
		logic            pixel_written;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            effect_running;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lbrs_cmd_if cmd_ch ();
	lbrs_pix_if pix_ch ();

	led_blink_rainbow_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.pix       (pix_ch)
	);

	cmd_item_t pending_cmds[$];
	pixel_t    pixel_expected[$];

	logic [CH_W-1:0]  color_r, color_g, color_b, sat_reg, val_reg;
	logic [HUE_W-1:0] step_reg;
	logic [1:0]       fx_mode;
	logic [PH_W-1:0]  phases_left;
	logic             blink_on;
	logic [HUE_W-1:0] hue;

	int send_idle_pct, recv_stall_pct, rx_stall_left;
	logic send_hold;
	int err_count, requests_sent, results_checked, rainbow_pixels, reg_writes;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic pixel_t advance_pixel(input cmd_item_t it);
		pixel_t px;
		logic [TIMES_W-1:0] times;
		logic show;
		int unsigned s, v, f, p, q, t, next_hue;
		px = '0;
		show = 1'b0;
		times = it.blink_times;
		case (it.func)
			FUNC_TICK: begin
				if (fx_mode == MODE_RAINBOW) begin
					s = sat_reg;
					v = val_reg;
					f = hue % 60;
					p = v * (255 - s) / 255;
					q = v * (15300 - s * f) / 15300;
					t = v * (15300 - s * (60 - f)) / 15300;
					case (hue / 60)
						0: {px.red, px.green, px.blue} = {v[7:0], t[7:0], p[7:0]};
						1: {px.red, px.green, px.blue} = {q[7:0], v[7:0], p[7:0]};
						2: {px.red, px.green, px.blue} = {p[7:0], v[7:0], t[7:0]};
						3: {px.red, px.green, px.blue} = {p[7:0], q[7:0], v[7:0]};
						4: {px.red, px.green, px.blue} = {t[7:0], p[7:0], v[7:0]};
						default: {px.red, px.green, px.blue} = {v[7:0], p[7:0], q[7:0]};
					endcase
					next_hue = (int'(hue) + int'(step_reg)) % 360;
					hue = next_hue[HUE_W-1:0];
					px.pixel_written = 1'b1;
					rainbow_pixels++;
				end else if (fx_mode == MODE_CONTINUOUS) begin
					blink_on = ~blink_on;
					px.pixel_written = 1'b1;
					show = blink_on;
				end else if (fx_mode == MODE_COUNTED) begin
					if (phases_left != 0)
						phases_left = phases_left - 1'b1;
					px.pixel_written = 1'b1;
					show = phases_left[0];
					if (phases_left == 0)
						fx_mode = MODE_STOPPED;
				end
			end
			FUNC_ON: begin
				fx_mode = MODE_STOPPED;
				px.pixel_written = 1'b1;
				show = 1'b1;
			end
			FUNC_OFF: begin
				fx_mode = MODE_STOPPED;
				px.pixel_written = 1'b1;
			end
			FUNC_BLINK: begin
				if (17'(times) > MAX_BLINKS)
					times = MAX_BLINKS[TIMES_W-1:0];
				if (times == 0) begin
					fx_mode = MODE_STOPPED;
					phases_left = '0;
					px.pixel_written = 1'b1;
				end else begin
					fx_mode = MODE_COUNTED;
					phases_left = {times, 1'b0};
				end
			end
			FUNC_CONT: begin
				fx_mode = MODE_CONTINUOUS;
				blink_on = 1'b0;
			end
			FUNC_RAINBOW: fx_mode = MODE_RAINBOW;
			default: ;
		endcase
		if (show)
			{px.red, px.green, px.blue} = {color_r, color_g, color_b};
		px.effect_running = (fx_mode != MODE_STOPPED);
		return px;
	endfunction

	// Driver: holds a request until it is taken, then offers the next one.
	always @(posedge clk) begin : drive_cmds
		logic busy;
		busy = cmd_ch.valid;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				pixel_expected.push_back(advance_pixel(pending_cmds.pop_front()));
				requests_sent++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (pending_cmds.size() > 0 && !send_hold &&
						$urandom_range(99) >= send_idle_pct) begin
					cmd_ch.valid       <= 1'b1;
					cmd_ch.func        <= pending_cmds[0].func;
					cmd_ch.blink_times <= pending_cmds[0].blink_times;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (rx_stall_left > 0)
			rx_stall_left <= rx_stall_left - 1;
	end

	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (!arst_n) begin
			pix_ch.ready <= 1'b0;
		end else begin
			if (pix_ch.valid && pix_ch.ready) begin
				results_checked++;
				if (pixel_expected.size() == 0) begin
					$error("pixel result with no request outstanding");
					err_count++;
				end else begin
					want = pixel_expected.pop_front();
					if (pix_ch.pixel_written !== want.pixel_written) begin
						$error("pixel_written: expected %0d, got %0d",
							want.pixel_written, pix_ch.pixel_written);
						err_count++;
					end
					if (pix_ch.red !== want.red) begin
						$error("red: expected %0d, got %0d", want.red, pix_ch.red);
						err_count++;
					end
					if (pix_ch.green !== want.green) begin
						$error("green: expected %0d, got %0d", want.green, pix_ch.green);
						err_count++;
					end
					if (pix_ch.blue !== want.blue) begin
						$error("blue: expected %0d, got %0d", want.blue, pix_ch.blue);
						err_count++;
					end
					if (pix_ch.effect_running !== want.effect_running) begin
						$error("effect_running: expected %0d, got %0d",
							want.effect_running, pix_ch.effect_running);
						err_count++;
					end
				end
			end
			pix_ch.ready <= (rx_stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_COLOR_RED:   color_r = val[CH_W-1:0];
			REG_COLOR_GREEN: color_g = val[CH_W-1:0];
			REG_COLOR_BLUE:  color_b = val[CH_W-1:0];
			REG_SATURATION:  sat_reg = val[CH_W-1:0];
			REG_VALUE:       val_reg = val[CH_W-1:0];
			REG_HUE_STEP:    step_reg = val;
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all_regs(input int r, input int g, input int b, input int s,
			input int v, input int step);
		write_reg(REG_COLOR_RED, CFG_DATA_W'(r));
		write_reg(REG_COLOR_GREEN, CFG_DATA_W'(g));
		write_reg(REG_COLOR_BLUE, CFG_DATA_W'(b));
		write_reg(REG_SATURATION, CFG_DATA_W'(s));
		write_reg(REG_VALUE, CFG_DATA_W'(v));
		write_reg(REG_HUE_STEP, CFG_DATA_W'(step));
		@(negedge clk);
	endtask

	task automatic push_item(input logic [FUNC_W-1:0] func, input logic [TIMES_W-1:0] times);
		cmd_item_t it;
		it.func = func;
		it.blink_times = times;
		pending_cmds.push_back(it);
	endtask

	task automatic drain_all();
		while (pending_cmds.size() > 0 || pixel_expected.size() > 0 || cmd_ch.valid)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Mostly a command followed by a run of ticks, with spare codes and stray ticks mixed in.
	task automatic queue_random_items(input int n);
		int made, pick, runs;
		logic [TIMES_W-1:0] times;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(99);
			times = TIMES_W'($urandom);
			runs = $urandom_range(16);
			if (pick < 12) begin
				push_item(FUNC_ON, times);
			end else if (pick < 22) begin
				push_item(FUNC_OFF, times);
			end else if (pick < 45) begin
				if ($urandom_range(9) < 7)
					times = TIMES_W'($urandom_range(6));
				else if ($urandom_range(1) == 0)
					times = TIMES_W'($urandom_range(40, 7));
				if (times <= 6)
					runs = 2 * times + $urandom_range(3);
				push_item(FUNC_BLINK, times);
			end else if (pick < 60) begin
				push_item(FUNC_CONT, times);
			end else if (pick < 80) begin
				push_item(FUNC_RAINBOW, times);
			end else if (pick < 84) begin
				push_item($urandom_range(1) ? FUNC_SPARE_HI : FUNC_SPARE_LO, times);
				made--;
				runs = 0;
			end else begin
				runs = 0;
				push_item(FUNC_TICK, times);
			end
			made++;
			for (int i = 0; i < runs; i++) begin
				push_item(FUNC_TICK, TIMES_W'($urandom));
				made++;
			end
		end
	endtask

	task automatic run_random_phase(input int send_pct, input int recv_pct, input int n);
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		queue_random_items(n);
		drain_all();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_COLOR_RED;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = FUNC_TICK;
		cmd_ch.blink_times = '0;
		pix_ch.ready = 1'b0;
		send_hold = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		rx_stall_left = 0;
		err_count = 0;
		requests_sent = 0;
		results_checked = 0;
		rainbow_pixels = 0;
		reg_writes = 0;
		color_r = '0;
		color_g = '0;
		color_b = '0;
		sat_reg = SAT_RESET;
		val_reg = VAL_RESET;
		step_reg = HUE_STEP_RESET;
		fx_mode = MODE_STOPPED;
		phases_left = '0;
		blink_on = 1'b0;
		hue = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part runs with the reset values of the rainbow registers.
		write_reg(REG_COLOR_RED, 9'h0FF);
		write_reg(REG_COLOR_GREEN, 9'h000);
		write_reg(REG_COLOR_BLUE, 9'h05A);
		@(negedge clk);
		push_item(FUNC_TICK, 10'h3FF);
		push_item(FUNC_ON, 10'h000);
		push_item(FUNC_OFF, 10'h3FF);
		push_item(FUNC_SPARE_LO, 10'h155);
		push_item(FUNC_SPARE_HI, 10'h2AA);
		push_item(FUNC_BLINK, 10'h000);
		push_item(FUNC_BLINK, 10'h001);
		repeat (3) push_item(FUNC_TICK, 10'h000);
		push_item(FUNC_BLINK, 10'h3FF);
		repeat (3) push_item(FUNC_TICK, 10'h3FF);
		push_item(FUNC_ON, 10'h3FF);
		push_item(FUNC_CONT, 10'h000);
		repeat (3) push_item(FUNC_TICK, 10'h000);
		push_item(FUNC_RAINBOW, 10'h000);
		repeat (2) push_item(FUNC_TICK, 10'h000);
		push_item(FUNC_OFF, 10'h000);
		push_item(FUNC_RAINBOW, 10'h3FF);
		repeat (2) push_item(FUNC_TICK, 10'h000);
		drain_all();

		write_all_regs(255, 0, 129, 255, 255, 359);
		run_random_phase(0, 0, 400);

		write_all_regs(0, 0, 0, 0, 0, 1);
		write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
		run_random_phase(62, 0, 400);

		write_all_regs($urandom_range(255), $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(255), 0);
		write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
		run_random_phase(0, 62, 400);

		write_all_regs($urandom_range(255), $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(255), 511);
		run_random_phase(29, 29, 400);

		// The receiver holds off long enough that the command channel backs up,
		// then the sender pauses until every outstanding request has come back.
		write_all_regs($urandom_range(255), $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(255), $urandom_range(359, 1));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random_items(80);
		while (pending_cmds.size() > 70)
			@(negedge clk);
		rx_stall_left = 300;
		while (rx_stall_left > 0)
			@(negedge clk);
		while (pending_cmds.size() > 30)
			@(negedge clk);
		send_hold = 1'b1;
		while (pixel_expected.size() > 0 || cmd_ch.valid)
			@(negedge clk);
		repeat (20) @(negedge clk);
		send_hold = 1'b0;
		drain_all();
		run_random_phase(29, 29, 400);

		$display("covered %0d requests and %0d pixel results (%0d rainbow pixels)",
			requests_sent, results_checked, rainbow_pixels);
		$display("over %0d register writes and five handshake idling patterns", reg_writes);
		if (err_count == 0)
			$display("led_blink_rainbow_sequencer_tb: done, clean");
		else
			$display("led_blink_rainbow_sequencer_tb: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("led_blink_rainbow_sequencer_tb: done, errors");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+design
design/lbrs_pkg.sv
design/lbrs_if.sv
design/lbrs_ctrl.sv
design/lbrs_datapath.sv
design/led_blink_rainbow_sequencer.sv
tb/led_blink_rainbow_sequencer_tb.sv
